>>> src/gtr_pkg.sv
// Shared types and constants for the glob-to-regex translator.
// Used by the top level, the front, queue and back stages, and the checker.
// Depends on nothing.
package gtr_pkg;

  // Brace nesting bound and the counter width it needs.
  localparam int MAX_BRACE_DEPTH = 255;
  localparam int DEPTH_W         = $clog2(MAX_BRACE_DEPTH + 1);

  // Queue between front and back; the depth must be a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters with a special meaning.
  localparam logic [7:0] CH_CARET  = 8'h5E;  // ^
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // $
  localparam logic [7:0] CH_BANG   = 8'h21;  // !
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
  localparam logic [7:0] CH_PIPE   = 8'h7C;  // |
  localparam logic [7:0] CH_STAR   = 8'h2A;  // *
  localparam logic [7:0] CH_QMARK  = 8'h3F;  // ?
  localparam logic [7:0] CH_DOT    = 8'h2E;  // .
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]

  typedef enum logic [0:0] {
    CMD_CHAR = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_STRAY_CLOSE  = 3'd1,
    ST_OPEN_BRACE   = 3'd2,
    ST_OPEN_SET     = 3'd3,
    ST_TRAIL_ESCAPE = 3'd4,
    ST_TOO_DEEP     = 3'd5
  } status_t;

  // One translated request: up to three result bytes and their common flags.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] chars;
    logic            done;
    status_t         status;
  } entry_t;

endpackage

>>> src/gtr_chan_if.sv
// Valid/ready channel interfaces for the translator's input and result streams.
// Does not use gtr_pkg.
interface gtr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pattern_char;

  modport source (output valid, command, pattern_char, input ready);
  modport sink (input valid, command, pattern_char, output ready);
endinterface

interface gtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       pattern_done;
  logic [2:0] status;

  modport source (output valid, out_char, char_valid, run_last, pattern_done, status,
                  input ready);
  modport sink (input valid, out_char, char_valid, run_last, pattern_done, status,
                output ready);
endinterface

>>> src/glob_to_regex_translator_unit.sv
// Top level of the glob-to-regex translator: front, queue and back stages.
// Depends on gtr_pkg, gtr_chan_if, gtr_front, gtr_queue and gtr_back.
//
// Usage:
//   in_chan carries one request per glob byte (command 0, pattern_char) or an
//   end-of-pattern request (command 1). out_chan carries result bytes, one per
//   transfer; run_last marks the final result of a request, pattern_done marks
//   the results of an end request, and status reports an error with
//   char_valid low. A request that raises an error, or any byte after one,
//   yields no result.
//   Path: the results of a request pass through the queue, the back stage's
//   current-entry register and the output register before they reach out_chan.
//   Flow: the back stage sends one result per cycle while ready is high. A
//   request has one to three results; requests without results are taken at
//   the input and never reach the queue. A two-entry queue lets the front keep
//   accepting while the back drains.
//   Reset (rst_n low, synchronous) empties the queue and output register and
//   starts a fresh pattern. When the receiver holds ready low the result stays
//   on the port; the front keeps accepting until the queue fills.
module glob_to_regex_translator_unit (
  input  logic      clk,
  input  logic      rst_n,
  gtr_in_if.sink    in_chan,
  gtr_out_if.source out_chan
);

  logic            push_valid, push_ready;
  gtr_pkg::entry_t push_data;
  logic            pop_valid, pop_ready;
  gtr_pkg::entry_t pop_data;

  gtr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  gtr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule

>>> src/gtr_front.sv
// Front stage: accepts glob requests, tracks the pattern state and classifies
// each request into a queue entry of up to three regex bytes. Uses gtr_pkg.
module gtr_front (
  input  logic            clk,
  input  logic            rst_n,
  gtr_in_if.sink          in_chan,
  output logic            push_valid,
  output gtr_pkg::entry_t push_data,
  input  logic            push_ready
);

  typedef enum logic [2:0] {
    M_NORMAL,
    M_ESCAPE,
    M_SET_OPEN,
    M_SET_BANG,
    M_SET_BODY
  } mode_t;

  mode_t                        mode_r, mode_nxt;
  logic [gtr_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic                         at_start_r, at_start_nxt;
  gtr_pkg::status_t             err_r, err_nxt;

  logic       accept;
  logic [7:0] c;
  logic [7:0] e0, e1;
  logic [1:0] n;
  gtr_pkg::status_t end_st;
  gtr_pkg::entry_t  ent;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && push_ready;
  assign c             = in_chan.pattern_char;

  always_comb begin
    mode_nxt     = mode_r;
    depth_nxt    = depth_r;
    at_start_nxt = at_start_r;
    err_nxt      = err_r;
    e0           = '0;
    e1           = '0;
    n            = 2'd0;
    end_st       = err_r;
    ent          = '0;
    ent.status   = gtr_pkg::ST_OK;

    if (in_chan.command == gtr_pkg::CMD_END) begin
      if (err_r == gtr_pkg::ST_OK) begin
        priority if (mode_r == M_ESCAPE) end_st = gtr_pkg::ST_TRAIL_ESCAPE;
        else if (mode_r != M_NORMAL) end_st = gtr_pkg::ST_OPEN_SET;
        else if (depth_r != '0) end_st = gtr_pkg::ST_OPEN_BRACE;
        else end_st = gtr_pkg::ST_OK;
      end
      ent.done   = 1'b1;
      ent.status = end_st;
      if (end_st != gtr_pkg::ST_OK) begin
        ent.cnt = 2'd1;
      end else if (at_start_r) begin
        ent.cnt      = 2'd2;
        ent.chars[0] = gtr_pkg::CH_CARET;
        ent.chars[1] = gtr_pkg::CH_DOLLAR;
      end else begin
        ent.cnt      = 2'd1;
        ent.chars[0] = gtr_pkg::CH_DOLLAR;
      end
      // Every end request returns the block to its idle pattern state.
      mode_nxt     = M_NORMAL;
      depth_nxt    = '0;
      at_start_nxt = 1'b1;
      err_nxt      = gtr_pkg::ST_OK;
    end else if (err_r == gtr_pkg::ST_OK) begin
      unique case (mode_r)
        M_ESCAPE: begin
          e0 = c; n = 2'd1; mode_nxt = M_NORMAL;
        end
        M_SET_OPEN: begin
          n = 2'd1;
          if (c == gtr_pkg::CH_BANG) begin
            e0 = gtr_pkg::CH_CARET; mode_nxt = M_SET_BANG;
          end else begin
            e0 = c; mode_nxt = M_SET_BODY;
          end
        end
        M_SET_BANG: begin
          e0 = c; n = 2'd1; mode_nxt = M_SET_BODY;
        end
        M_SET_BODY: begin
          e0 = c; n = 2'd1;
          if (c == gtr_pkg::CH_RBRACK) mode_nxt = M_NORMAL;
        end
        M_NORMAL: begin
          priority if (c == gtr_pkg::CH_BSLASH) begin
            e0 = gtr_pkg::CH_BSLASH; n = 2'd1; mode_nxt = M_ESCAPE;
          end else if (c == gtr_pkg::CH_DOT || c == gtr_pkg::CH_PIPE ||
                       c == gtr_pkg::CH_LPAREN || c == gtr_pkg::CH_RPAREN ||
                       c == gtr_pkg::CH_PLUS) begin
            e0 = gtr_pkg::CH_BSLASH; e1 = c; n = 2'd2;
          end else if (c == gtr_pkg::CH_STAR) begin
            e0 = gtr_pkg::CH_DOT; e1 = gtr_pkg::CH_STAR; n = 2'd2;
          end else if (c == gtr_pkg::CH_QMARK) begin
            e0 = gtr_pkg::CH_DOT; n = 2'd1;
          end else if (c == gtr_pkg::CH_LBRACE) begin
            if (depth_r == gtr_pkg::DEPTH_W'(gtr_pkg::MAX_BRACE_DEPTH)) begin
              err_nxt = gtr_pkg::ST_TOO_DEEP;
            end else begin
              depth_nxt = depth_r + gtr_pkg::DEPTH_W'(1);
              e0 = gtr_pkg::CH_LPAREN; n = 2'd1;
            end
          end else if (c == gtr_pkg::CH_RBRACE) begin
            if (depth_r == '0) begin
              err_nxt = gtr_pkg::ST_STRAY_CLOSE;
            end else begin
              depth_nxt = depth_r - gtr_pkg::DEPTH_W'(1);
              e0 = gtr_pkg::CH_RPAREN; n = 2'd1;
            end
          end else if (c == gtr_pkg::CH_COMMA) begin
            e0 = (depth_r != '0) ? gtr_pkg::CH_PIPE : gtr_pkg::CH_COMMA;
            n  = 2'd1;
          end else if (c == gtr_pkg::CH_LBRACK) begin
            e0 = gtr_pkg::CH_LBRACK; n = 2'd1; mode_nxt = M_SET_OPEN;
          end else begin
            e0 = c; n = 2'd1;
          end
        end
        default: begin
          mode_nxt = M_NORMAL;
        end
      endcase

      // The caret prefix rides in front of the first bytes of a pattern.
      if (n != 2'd0) begin
        if (at_start_r) begin
          ent.cnt      = n + 2'd1;
          ent.chars[0] = gtr_pkg::CH_CARET;
          ent.chars[1] = e0;
          ent.chars[2] = e1;
          at_start_nxt = 1'b0;
        end else begin
          ent.cnt      = n;
          ent.chars[0] = e0;
          ent.chars[1] = e1;
        end
      end
    end
  end

  assign push_valid = accept && (ent.cnt != 2'd0);
  assign push_data  = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_NORMAL;
      depth_r    <= '0;
      at_start_r <= 1'b1;
      err_r      <= gtr_pkg::ST_OK;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      depth_r    <= depth_nxt;
      at_start_r <= at_start_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

>>> src/gtr_queue.sv
// Short first-in first-out queue of translated entries between front and back.
// Uses gtr_pkg for the entry type and the queue depth.
module gtr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  gtr_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output gtr_pkg::entry_t pop_data
);

  gtr_pkg::entry_t             slot_r [gtr_pkg::QDEPTH];
  logic [gtr_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [gtr_pkg::QCNT_W-1:0]  count_r;
  logic                        do_push, do_pop;

  assign push_ready = (count_r != gtr_pkg::QCNT_W'(gtr_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + gtr_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + gtr_pkg::QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + gtr_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - gtr_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/gtr_back.sv
// Back stage: takes queue entries and sends their bytes one result per cycle
// unless ready stalls it, via a registered output. Uses gtr_pkg, gtr_out_if.
module gtr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  gtr_pkg::entry_t pop_data,
  gtr_out_if.source       out_chan
);

  gtr_pkg::entry_t  cur_r;
  logic             cur_valid_r;
  logic [1:0]       idx_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             char_valid_r, run_last_r, done_r;
  gtr_pkg::status_t status_r;

  logic slot_free, emit, last, cur_load;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign emit      = cur_valid_r && slot_free;
  assign last      = (idx_r == cur_r.cnt - 2'd1);
  assign cur_load  = pop_valid && (!cur_valid_r || (emit && last));
  assign pop_ready = cur_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cur_load) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (emit) begin
        if (last) cur_valid_r <= 1'b0;
        idx_r <= idx_r + 2'd1;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) cur_r <= pop_data;
    if (emit) begin
      out_char_r   <= cur_r.chars[idx_r];
      char_valid_r <= (cur_r.status == gtr_pkg::ST_OK);
      run_last_r   <= last;
      done_r       <= cur_r.done;
      status_r     <= cur_r.status;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_char     = out_char_r;
  assign out_chan.char_valid   = char_valid_r;
  assign out_chan.run_last     = run_last_r;
  assign out_chan.pattern_done = done_r;
  assign out_chan.status       = status_r;

endmodule

>>> src/gtr_checker.sv
// Port-level checks for the glob-to-regex translator, bound to the top level.
// Depends on gtr_pkg for the status codes.
module gtr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       char_valid,
  input logic       run_last,
  input logic       pattern_done,
  input logic [2:0] status
);

  // A stalled result must stay offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An error result is a lone, empty, final result of an end request.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |->
      pattern_done && run_last && out_char == 8'd0 && status != 3'(gtr_pkg::ST_OK))
    else $error("malformed error result");

  // A byte result always carries an ok status.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && char_valid |-> status == 3'(gtr_pkg::ST_OK))
    else $error("byte result with error status");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind glob_to_regex_translator_unit gtr_checker u_gtr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_char     (out_chan.out_char),
  .char_valid   (out_chan.char_valid),
  .run_last     (out_chan.run_last),
  .pattern_done (out_chan.pattern_done),
  .status       (out_chan.status)
);
